### rtl/assert_macros.svh
// Assertion macros used by the port-level checker file of the moving average block.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication within the same clock edge, disabled while reset is asserted.
`define MMA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Implication into the following clock edge, disabled while reset is asserted.
`define MMA_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

### rtl/mma_pkg.sv
// Package of the multichannel moving average block: field widths, default window
// sizes and the control struct passed from the top level to each lane. No dependencies.
`default_nettype none

package mma_pkg;

	localparam int IMU_W      = 16;
	localparam int ADC_W      = 10;
	localparam int EMG_LANE_W = ADC_W + 1;
	localparam int FORCE_W    = ADC_W + 1;

	localparam int IMU_LANES = 6;
	localparam int EMG_LANES = 2;

	localparam int DEF_IMU_WINDOW   = 16;
	localparam int DEF_EMG_WINDOW   = 16;
	localparam int DEF_FORCE_WINDOW = 16;

	typedef struct packed {
		logic take;
		logic step;
	} lane_ctrl_t;

endpackage

`default_nettype wire

### rtl/mma_lane.sv
// One averaging lane: a ring of the last WINDOW samples with a registered read,
// and a running sum whose scaled value is the window average. Depends on mma_pkg.
`default_nettype none

module mma_lane #(
	parameter int WINDOW = mma_pkg::DEF_FORCE_WINDOW,
	parameter int IN_W   = mma_pkg::FORCE_W
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mma_pkg::lane_ctrl_t     ctrl,
	input  logic signed [IN_W-1:0]  sample,
	output logic signed [IN_W-1:0]  avg
);
	import mma_pkg::*;

	localparam int IDX_W = $clog2(WINDOW);
	localparam int SUM_W = IN_W + IDX_W;

	logic [IDX_W-1:0]        slot_q;
	logic                    wrapped_q;
	logic signed [IN_W-1:0]  ring_mem [WINDOW];
	logic signed [IN_W-1:0]  old_s1;
	logic signed [IN_W-1:0]  new_s1;
	logic                    wrapped_s1;
	logic signed [IN_W-1:0]  old_used;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [SUM_W-1:0] sum_next;

	// Until the ring has wrapped once, the slot being overwritten has never been
	// written and counts as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q    <= '0;
			wrapped_q <= 1'b0;
		end else if (ctrl.take) begin
			if (slot_q == IDX_W'(WINDOW - 1)) begin
				slot_q    <= '0;
				wrapped_q <= 1'b1;
			end else begin
				slot_q <= slot_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.take) begin
			ring_mem[slot_q] <= sample;
			old_s1           <= ring_mem[slot_q];
			new_s1           <= sample;
			wrapped_s1       <= wrapped_q;
		end
	end

	assign old_used = wrapped_s1 ? old_s1 : '0;
	assign sum_next = sum_q + SUM_W'(new_s1) - SUM_W'(old_used);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctrl.step) begin
			sum_q <= sum_next;
		end
	end

	assign avg = IN_W'(sum_next >>> IDX_W);

endmodule

`default_nettype wire

### rtl/multichannel_moving_average.sv
// Top level of the nine-channel moving average block: handshake control, force
// zero correction, the nine lanes and the merged output register. Depends on mma_pkg and mma_lane.
`default_nettype none

// Takes one sample set per word and returns one word holding the floor-rounded window
// averages of all nine channels. A new word is accepted in every cycle while the output
// register is empty or being taken; each result passes the registered ring read in each
// lane and then the output register, loaded together with the running sum. Rings read
// as zero until they have wrapped once, so no clearing pass follows reset. Window sizes
// must be powers of two. The force zero reference zero_ref_q must be written through
// cfg_we and cfg_wdata only while the block is idle; the block does not enforce this.
module multichannel_moving_average #(
	parameter int IMU_WINDOW   = mma_pkg::DEF_IMU_WINDOW,
	parameter int EMG_WINDOW   = mma_pkg::DEF_EMG_WINDOW,
	parameter int FORCE_WINDOW = mma_pkg::DEF_FORCE_WINDOW
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [mma_pkg::ADC_W-1:0]          cfg_wdata,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [mma_pkg::IMU_W-1:0]   gyro_x,
	input  logic signed [mma_pkg::IMU_W-1:0]   gyro_y,
	input  logic signed [mma_pkg::IMU_W-1:0]   gyro_z,
	input  logic signed [mma_pkg::IMU_W-1:0]   accel_x,
	input  logic signed [mma_pkg::IMU_W-1:0]   accel_y,
	input  logic signed [mma_pkg::IMU_W-1:0]   accel_z,
	input  logic [mma_pkg::ADC_W-1:0]          emg_first,
	input  logic [mma_pkg::ADC_W-1:0]          emg_second,
	input  logic [mma_pkg::ADC_W-1:0]          force_raw,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [mma_pkg::IMU_W-1:0]   avg_gyro_x,
	output logic signed [mma_pkg::IMU_W-1:0]   avg_gyro_y,
	output logic signed [mma_pkg::IMU_W-1:0]   avg_gyro_z,
	output logic signed [mma_pkg::IMU_W-1:0]   avg_accel_x,
	output logic signed [mma_pkg::IMU_W-1:0]   avg_accel_y,
	output logic signed [mma_pkg::IMU_W-1:0]   avg_accel_z,
	output logic [mma_pkg::ADC_W-1:0]          avg_emg_first,
	output logic [mma_pkg::ADC_W-1:0]          avg_emg_second,
	output logic signed [mma_pkg::FORCE_W-1:0] avg_force
);
	import mma_pkg::*;

	logic                        advance;
	logic                        s1_valid_q;
	logic                        out_valid_q;
	logic [ADC_W-1:0]            zero_ref_q;
	lane_ctrl_t                  lane_ctrl;

	logic signed [IMU_W-1:0]      imu_smp [IMU_LANES];
	logic signed [IMU_W-1:0]      imu_avg [IMU_LANES];
	logic signed [IMU_W-1:0]      imu_res_q [IMU_LANES];
	logic signed [EMG_LANE_W-1:0] emg_smp [EMG_LANES];
	logic signed [EMG_LANE_W-1:0] emg_avg [EMG_LANES];
	logic [ADC_W-1:0]             emg_res_q [EMG_LANES];
	logic signed [FORCE_W-1:0]    force_smp;
	logic signed [FORCE_W-1:0]    force_avg;
	logic signed [FORCE_W-1:0]    force_res_q;

	assign advance        = !out_valid_q || out_ready;
	assign in_ready       = advance;
	assign lane_ctrl.take = in_valid && advance;
	assign lane_ctrl.step = s1_valid_q && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			zero_ref_q  <= '0;
		end else begin
			if (cfg_we) begin
				zero_ref_q <= cfg_wdata;
			end
			if (advance) begin
				s1_valid_q  <= in_valid;
				out_valid_q <= s1_valid_q;
			end
		end
	end

	assign imu_smp[0] = gyro_x;
	assign imu_smp[1] = gyro_y;
	assign imu_smp[2] = gyro_z;
	assign imu_smp[3] = accel_x;
	assign imu_smp[4] = accel_y;
	assign imu_smp[5] = accel_z;

	assign emg_smp[0] = signed'({1'b0, emg_first});
	assign emg_smp[1] = signed'({1'b0, emg_second});

	assign force_smp = signed'({1'b0, force_raw}) - signed'({1'b0, zero_ref_q});

	for (genvar i = 0; i < IMU_LANES; i++) begin : g_imu
		mma_lane #(
			.WINDOW (IMU_WINDOW),
			.IN_W   (IMU_W)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (lane_ctrl),
			.sample (imu_smp[i]),
			.avg    (imu_avg[i])
		);
	end

	for (genvar i = 0; i < EMG_LANES; i++) begin : g_emg
		mma_lane #(
			.WINDOW (EMG_WINDOW),
			.IN_W   (EMG_LANE_W)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (lane_ctrl),
			.sample (emg_smp[i]),
			.avg    (emg_avg[i])
		);
	end

	mma_lane #(
		.WINDOW (FORCE_WINDOW),
		.IN_W   (FORCE_W)
	) u_force_lane (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (lane_ctrl),
		.sample (force_smp),
		.avg    (force_avg)
	);

	// Output register gathering the nine lane averages into one word.
	always_ff @(posedge clk) begin
		if (lane_ctrl.step) begin
			for (int i = 0; i < IMU_LANES; i++) begin
				imu_res_q[i] <= imu_avg[i];
			end
			for (int i = 0; i < EMG_LANES; i++) begin
				emg_res_q[i] <= emg_avg[i][ADC_W-1:0];
			end
			force_res_q <= force_avg;
		end
	end

	assign out_valid      = out_valid_q;
	assign avg_gyro_x     = imu_res_q[0];
	assign avg_gyro_y     = imu_res_q[1];
	assign avg_gyro_z     = imu_res_q[2];
	assign avg_accel_x    = imu_res_q[3];
	assign avg_accel_y    = imu_res_q[4];
	assign avg_accel_z    = imu_res_q[5];
	assign avg_emg_first  = emg_res_q[0];
	assign avg_emg_second = emg_res_q[1];
	assign avg_force      = force_res_q;

endmodule

`default_nettype wire

### rtl/mma_checker.sv
// Port-level checks for the multichannel moving average block and the bind that
// attaches them to the top level. Depends on mma_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module mma_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic signed [mma_pkg::FORCE_W-1:0] avg_force
);
	import mma_pkg::*;

	// An empty output register never holds back the input side.
	`MMA_ASSERT_IMP(a_ready_when_empty, !out_valid, in_ready)

	// A result appears only for a word that was accepted earlier.
	`MMA_ASSERT_IMP(a_result_has_source, $rose(out_valid), $past(in_valid && in_ready, 2))

	// A stalled result stays offered, with its force average unchanged.
	`MMA_ASSERT_NXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(avg_force))

endmodule

bind multichannel_moving_average mma_checker u_mma_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.avg_force (avg_force)
);

`default_nettype wire

### sim/multichannel_moving_average_checker.sv
// Checker for the nine-channel moving average block: predicts every result word from the
// accepted sample sets and the zero reference, and compares field by field.
// Depends on mma_pkg; instantiated beside the block by multichannel_moving_average_test.
`default_nettype none

module multichannel_moving_average_checker #(
	parameter int IMU_WINDOW   = mma_pkg::DEF_IMU_WINDOW,
	parameter int EMG_WINDOW   = mma_pkg::DEF_EMG_WINDOW,
	parameter int FORCE_WINDOW = mma_pkg::DEF_FORCE_WINDOW
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [mma_pkg::ADC_W-1:0]          cfg_wdata,
	input  logic                               in_valid,
	input  logic                               in_ready,
	input  logic signed [mma_pkg::IMU_W-1:0]   gyro_x,
	input  logic signed [mma_pkg::IMU_W-1:0]   gyro_y,
	input  logic signed [mma_pkg::IMU_W-1:0]   gyro_z,
	input  logic signed [mma_pkg::IMU_W-1:0]   accel_x,
	input  logic signed [mma_pkg::IMU_W-1:0]   accel_y,
	input  logic signed [mma_pkg::IMU_W-1:0]   accel_z,
	input  logic [mma_pkg::ADC_W-1:0]          emg_first,
	input  logic [mma_pkg::ADC_W-1:0]          emg_second,
	input  logic [mma_pkg::ADC_W-1:0]          force_raw,
	input  logic                               out_valid,
	input  logic                               out_ready,
	input  logic signed [mma_pkg::IMU_W-1:0]   avg_gyro_x,
	input  logic signed [mma_pkg::IMU_W-1:0]   avg_gyro_y,
	input  logic signed [mma_pkg::IMU_W-1:0]   avg_gyro_z,
	input  logic signed [mma_pkg::IMU_W-1:0]   avg_accel_x,
	input  logic signed [mma_pkg::IMU_W-1:0]   avg_accel_y,
	input  logic signed [mma_pkg::IMU_W-1:0]   avg_accel_z,
	input  logic [mma_pkg::ADC_W-1:0]          avg_emg_first,
	input  logic [mma_pkg::ADC_W-1:0]          avg_emg_second,
	input  logic signed [mma_pkg::FORCE_W-1:0] avg_force,
	output int                                 failures,
	output int                                 pending
);

	localparam int LANES      = 9;

	typedef logic [LANES-1:0][mma_pkg::IMU_W-1:0] avg_set_t;

	string lane_label [LANES] = '{"avg_gyro_x", "avg_gyro_y", "avg_gyro_z", "avg_accel_x",
		"avg_accel_y", "avg_accel_z", "avg_emg_first", "avg_emg_second", "avg_force"};

	int imu_ring [6][IMU_WINDOW];
	int emg_ring [2][EMG_WINDOW];
	int load_ring [FORCE_WINDOW];
	longint imu_sum [6];
	longint emg_sum [2];
	longint load_sum;
	int imu_slot;
	int emg_slot;
	int load_slot;
	logic [mma_pkg::ADC_W-1:0] zero_ref = '0;

	avg_set_t awaited_averages [$];
	avg_set_t want;
	avg_set_t got;
	int mismatches = 0;

	assign failures = mismatches;

	function automatic longint floor_mean(input longint total, input int size);
		if (total >= 0) begin
			return total / size;
		end
		return -((-total + size - 1) / size);
	endfunction

	function automatic avg_set_t advance_windows(input logic [5:0][mma_pkg::IMU_W-1:0] imu_in,
			input logic [1:0][mma_pkg::ADC_W-1:0] emg_in, input logic [mma_pkg::ADC_W-1:0] raw_load);
		avg_set_t result;
		longint mean;
		int sample;
		for (int k = 0; k < 6; k++) begin
			sample = int'($signed(imu_in[k]));
			imu_sum[k] = imu_sum[k] + longint'(sample - imu_ring[k][imu_slot]);
			imu_ring[k][imu_slot] = sample;
			mean = floor_mean(imu_sum[k], IMU_WINDOW);
			result[k] = mean[mma_pkg::IMU_W-1:0];
		end
		imu_slot = (imu_slot + 1) % IMU_WINDOW;
		for (int k = 0; k < 2; k++) begin
			sample = int'(emg_in[k]);
			emg_sum[k] = emg_sum[k] + longint'(sample - emg_ring[k][emg_slot]);
			emg_ring[k][emg_slot] = sample;
			mean = floor_mean(emg_sum[k], EMG_WINDOW);
			result[6 + k] = mean[mma_pkg::ADC_W-1:0];
		end
		emg_slot = (emg_slot + 1) % EMG_WINDOW;
		sample = int'(raw_load) - int'(zero_ref);
		load_sum = load_sum + longint'(sample - load_ring[load_slot]);
		load_ring[load_slot] = sample;
		load_slot = (load_slot + 1) % FORCE_WINDOW;
		mean = floor_mean(load_sum, FORCE_WINDOW);
		result[8] = mean[mma_pkg::FORCE_W-1:0];
		return result;
	endfunction

	task automatic note_failure(input string msg);
		mismatches++;
		$display("%0t: result check: %s", $realtime, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 6; k++) begin
				imu_sum[k] = 0;
				for (int j = 0; j < IMU_WINDOW; j++) imu_ring[k][j] = 0;
			end
			for (int k = 0; k < 2; k++) begin
				emg_sum[k] = 0;
				for (int j = 0; j < EMG_WINDOW; j++) emg_ring[k][j] = 0;
			end
			for (int j = 0; j < FORCE_WINDOW; j++) load_ring[j] = 0;
			load_sum = 0;
			imu_slot = 0;
			emg_slot = 0;
			load_slot = 0;
			zero_ref = '0;
			awaited_averages.delete();
			pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (awaited_averages.size() == 0) begin
					note_failure("result word with no sample set waiting for it");
				end else begin
					want = awaited_averages.pop_front();
					got[0] = avg_gyro_x;
					got[1] = avg_gyro_y;
					got[2] = avg_gyro_z;
					got[3] = avg_accel_x;
					got[4] = avg_accel_y;
					got[5] = avg_accel_z;
					got[6] = avg_emg_first;
					got[7] = avg_emg_second;
					got[8] = $unsigned(avg_force);
					for (int k = 0; k < LANES; k++) begin
						if (got[k] !== want[k]) begin
							note_failure($sformatf("%s is %h, expected %h",
								lane_label[k], got[k], want[k]));
						end
					end
				end
			end
			if (in_valid && in_ready) begin
				awaited_averages.push_back(advance_windows(
					{accel_z, accel_y, accel_x, gyro_z, gyro_y, gyro_x},
					{emg_second, emg_first}, force_raw));
			end
			if (cfg_we) begin
				zero_ref = cfg_wdata;
			end
			pending <= awaited_averages.size();
		end
	end

endmodule

`default_nettype wire

### sim/multichannel_moving_average_test.sv
// Top of the moving average testbench: clock, reset, sample set and zero reference stimulus,
// back-pressure on the result channel and the final verdict.
// Depends on mma_pkg, multichannel_moving_average and multichannel_moving_average_checker.
`default_nettype none

module multichannel_moving_average_test;

	localparam int CYCLE_LIMIT = 100000;
	localparam int SETTLE      = 8;
	localparam int PHASE_WORDS = 670;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic [5:0][mma_pkg::IMU_W-1:0] imu;
		logic [1:0][mma_pkg::ADC_W-1:0] emg;
		logic [mma_pkg::ADC_W-1:0]      fsr;
	} sample_set_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [mma_pkg::ADC_W-1:0] cfg_wdata;
	logic in_valid;
	logic in_ready;
	logic signed [mma_pkg::IMU_W-1:0] gyro_x, gyro_y, gyro_z;
	logic signed [mma_pkg::IMU_W-1:0] accel_x, accel_y, accel_z;
	logic [mma_pkg::ADC_W-1:0] emg_first, emg_second, force_raw;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [mma_pkg::IMU_W-1:0] avg_gyro_x, avg_gyro_y, avg_gyro_z;
	logic signed [mma_pkg::IMU_W-1:0] avg_accel_x, avg_accel_y, avg_accel_z;
	logic [mma_pkg::ADC_W-1:0] avg_emg_first, avg_emg_second;
	logic signed [mma_pkg::FORCE_W-1:0] avg_force;

	int failures;
	int pending;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	logic rx_hold = 1'b0;
	int cycle_count = 0;

	multichannel_moving_average dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.gyro_x(gyro_x),
		.gyro_y(gyro_y),
		.gyro_z(gyro_z),
		.accel_x(accel_x),
		.accel_y(accel_y),
		.accel_z(accel_z),
		.emg_first(emg_first),
		.emg_second(emg_second),
		.force_raw(force_raw),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.avg_gyro_x(avg_gyro_x),
		.avg_gyro_y(avg_gyro_y),
		.avg_gyro_z(avg_gyro_z),
		.avg_accel_x(avg_accel_x),
		.avg_accel_y(avg_accel_y),
		.avg_accel_z(avg_accel_z),
		.avg_emg_first(avg_emg_first),
		.avg_emg_second(avg_emg_second),
		.avg_force(avg_force)
	);

	multichannel_moving_average_checker averages_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.gyro_x(gyro_x),
		.gyro_y(gyro_y),
		.gyro_z(gyro_z),
		.accel_x(accel_x),
		.accel_y(accel_y),
		.accel_z(accel_z),
		.emg_first(emg_first),
		.emg_second(emg_second),
		.force_raw(force_raw),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.avg_gyro_x(avg_gyro_x),
		.avg_gyro_y(avg_gyro_y),
		.avg_gyro_z(avg_gyro_z),
		.avg_accel_x(avg_accel_x),
		.avg_accel_y(avg_accel_y),
		.avg_accel_z(avg_accel_z),
		.avg_emg_first(avg_emg_first),
		.avg_emg_second(avg_emg_second),
		.avg_force(avg_force),
		.failures(failures),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_ready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
	end

	function automatic logic [mma_pkg::IMU_W-1:0] pick_imu();
		int r;
		r = $urandom;
		case ($urandom_range(0, 9))
			0: r = 32'h0000_8000;
			1: r = 32'h0000_7FFF;
			2: r = 0;
			default: ;
		endcase
		return r[mma_pkg::IMU_W-1:0];
	endfunction

	function automatic logic [mma_pkg::ADC_W-1:0] pick_adc();
		int r;
		r = $urandom;
		case ($urandom_range(0, 9))
			0: r = 0;
			1: r = 1023;
			default: ;
		endcase
		return r[mma_pkg::ADC_W-1:0];
	endfunction

	function automatic sample_set_t random_sample();
		sample_set_t s;
		for (int k = 0; k < 6; k++) s.imu[k] = pick_imu();
		for (int k = 0; k < 2; k++) s.emg[k] = pick_adc();
		s.fsr = pick_adc();
		return s;
	endfunction

	function automatic sample_set_t extreme_sample(input bit high);
		sample_set_t s;
		for (int k = 0; k < 6; k++) s.imu[k] = high ? 16'h7FFF : 16'h8000;
		for (int k = 0; k < 2; k++) s.emg[k] = high ? '1 : '0;
		s.fsr = high ? '1 : '0;
		return s;
	endfunction

	task automatic offer_word(input sample_set_t s);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		gyro_x <= s.imu[0];
		gyro_y <= s.imu[1];
		gyro_z <= s.imu[2];
		accel_x <= s.imu[3];
		accel_y <= s.imu[4];
		accel_z <= s.imu[5];
		emg_first <= s.emg[0];
		emg_second <= s.emg[1];
		force_raw <= s.fsr;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_zero_ref(input logic [mma_pkg::ADC_W-1:0] value);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly random words, with occasional runs of full-scale words that fill a whole window.
	task automatic random_phase(input int count);
		int run;
		bit high;
		run = 0;
		high = 1'b0;
		for (int n = 0; n < count; n++) begin
			if (run == 0 && $urandom_range(0, 99) < 3) begin
				run = $urandom_range(16, 24);
				high = ($urandom_range(0, 1) == 1);
			end
			if (run > 0) begin
				offer_word(extreme_sample(high));
				run--;
			end else begin
				offer_word(random_sample());
			end
		end
	endtask

	task automatic hold_receiver();
		repeat (100) @(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	endtask

	initial begin
		int pick;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		gyro_x = '0;
		gyro_y = '0;
		gyro_z = '0;
		accel_x = '0;
		accel_y = '0;
		accel_z = '0;
		emg_first = '0;
		emg_second = '0;
		force_raw = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Warm-up from cleared windows at full scale, then the opposite extreme with the
		// largest zero reference so that the corrected force goes negative.
		set_zero_ref('0);
		repeat (12) offer_word(extreme_sample(1'b1));
		set_zero_ref('1);
		repeat (12) offer_word(extreme_sample(1'b0));

		tx_idle_pct = 26;
		rx_idle_pct = 48;
		pick = $urandom_range(1, 1022);
		set_zero_ref(pick[mma_pkg::ADC_W-1:0]);
		random_phase(PHASE_WORDS);

		tx_idle_pct = 48;
		rx_idle_pct = 26;
		set_zero_ref('0);
		random_phase(PHASE_WORDS / 2);
		drain();
		random_phase(PHASE_WORDS / 2);

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		set_zero_ref('1);
		fork
			hold_receiver();
			random_phase(PHASE_WORDS);
		join
		drain();

		if (failures == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

`default_nettype wire

### multichannel_moving_average.f
+incdir+rtl
rtl/mma_pkg.sv
rtl/mma_lane.sv
rtl/multichannel_moving_average.sv
rtl/mma_checker.sv
sim/multichannel_moving_average_checker.sv
sim/multichannel_moving_average_test.sv
